// ===== hw/rtl/wris_pkg.sv =====
// Package for the weighted record insertion sorter.
// Holds field widths, the controller state type and the command/status structs.
// No dependencies.
package wris_pkg;

    localparam int COORD_W       = 16;
    localparam int PRIO_W        = 16;
    localparam int RANK_W        = 6;
    localparam int KEY_W         = 22;
    localparam int BOX_W         = 4 * COORD_W;
    localparam int MAX_BOXES_DEF = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_CHK,
        S_ORD,
        S_OLD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;      // capture a new item, start insertion at the end
        logic rd_pos;    // read the entry just below the insert position
        logic rd_out;    // read the entry at the output index
        logic wr_shift;  // move the entry read last up by one place
        logic wr_new;    // write the new item at the insert position
        logic k_clr;
        logic k_inc;
        logic out_load;
        logic run_done;  // clear count and overflow after the last transfer
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic greater;
        logic final_item;
        logic last;
    } t_status;

endpackage

// ===== hw/rtl/wris_datapath.sv =====
// Datapath of the weighted record insertion sorter: key multiplier, sorted
// store memory, insert position, output index and output register.
// Depends on wris_pkg.
module wris_datapath
    import wris_pkg::*;
#(
    parameter int MaxBoxes = MAX_BOXES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic [RANK_W-1:0]    i_random_rank,
    input  logic [BOX_W-1:0]     i_box,
    input  logic                 i_final_box,
    output logic [BOX_W-1:0]     o_box,
    output logic [KEY_W-1:0]     o_sort_key,
    output logic                 o_end_of_run,
    output logic                 o_overflowed
);

    localparam int AW = (MaxBoxes > 1) ? $clog2(MaxBoxes) : 1;
    localparam int CW = $clog2(MaxBoxes + 1);
    localparam int EW = KEY_W + BOX_W;

    logic [EW-1:0] mem [MaxBoxes];
    logic [EW-1:0] r_rd;
    logic [KEY_W-1:0] r_key;
    logic [BOX_W-1:0] r_box;
    logic r_final;
    logic [CW-1:0] r_count, r_pos, r_k;
    logic r_ovf;
    logic [CW-1:0] pos_m1, k_p1;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] r_out;
    logic r_end;

    assign pos_m1  = r_pos - CW'(1);
    assign k_p1    = r_k + CW'(1);
    assign rd_addr = i_cmd.rd_out ? r_k[AW-1:0] : pos_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift) begin
            mem[r_pos[AW-1:0]] <= r_rd;
        end else if (i_cmd.wr_new) begin
            mem[r_pos[AW-1:0]] <= {r_key, r_box};
        end
        if (i_cmd.rd_pos || i_cmd.rd_out) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= KEY_W'(i_priority_req) * KEY_W'(i_random_rank);
            r_box   <= i_box;
            r_final <= i_final_box;
        end
        if (i_cmd.out_load) begin
            r_out <= r_rd;
            r_end <= (k_p1 == r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos <= r_count;
                if (r_count == CW'(MaxBoxes)) begin
                    r_ovf <= 1'b1;
                end
            end else if (i_cmd.wr_shift) begin
                r_pos <= pos_m1;
            end else if (i_cmd.run_done) begin
                r_pos <= '0;
            end
            if (i_cmd.wr_new) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.run_done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= k_p1;
            end
        end
    end

    assign o_status.full       = (r_count == CW'(MaxBoxes));
    assign o_status.pos_zero   = (r_pos == '0);
    assign o_status.greater    = (r_rd[EW-1 -: KEY_W] > r_key);
    assign o_status.final_item = r_final;
    assign o_status.last       = r_end;

    assign o_sort_key   = r_out[EW-1 -: KEY_W];
    assign o_box        = r_out[BOX_W-1:0];
    assign o_end_of_run = r_end;
    assign o_overflowed = r_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MaxBoxes)) else $error("store count beyond capacity");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_count) else $error("insert position beyond count");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_shift && i_cmd.wr_new)) else $error("two writes in one cycle");
    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> r_count != CW'(MaxBoxes)) else $error("insert into full store");

endmodule

// ===== hw/rtl/wris_ctrl.sv =====
// Controller of the weighted record insertion sorter: sequences insertion
// and output of a set. Depends on wris_pkg.
module wris_ctrl
    import wris_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.full ? S_CHK : S_RD;
                end
            end
            S_RD: begin
                if (i_status.pos_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_CHK;
                end else begin
                    o_cmd.rd_pos = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.greater) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.k_clr = 1'b1;
                n_state = i_status.final_item ? S_ORD : S_IDLE;
            end
            S_ORD: begin
                o_cmd.rd_out = 1'b1;
                n_state = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (i_status.last) begin
                        o_cmd.run_done = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output active together");
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.run_done |=> r_state == S_IDLE) else $error("run end not back to idle");
    a_insert_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_new |=> r_state == S_CHK) else $error("insert not followed by check");

endmodule

// ===== hw/rtl/weighted_record_insertion_sorter.sv =====
// Top level of the weighted record insertion sorter.
// Depends on wris_pkg, wris_ctrl and wris_datapath.
//
// Usage: each input transfer carries one box, a Q8.8 priority and a 6-bit
// rank. The key priority * rank is formed as the item is taken, and the box
// is inserted into a sorted store with a stable insertion sort: it lands after
// every stored box whose key is less than or equal to its own.
// Insertion: the next ready comes only once the item is placed. For each
// stored box with a larger key, the store memory reads the entry just below
// the insert position, compares its key and shifts it up by one place; then
// the new box is written. A box that ends up at the front is written with no
// last compare. When the store already holds MAX_BOXES boxes, the item is
// dropped and the overflow flag is set for the rest of the set.
// After the item marked final_box, the whole store is emitted in ascending
// key order; each result passes a memory read, the read data register and
// the output register, and the next read starts only when the receiver takes
// the current result. The last result carries end_of_run, and every result of
// the set carries the overflow flag. No input is taken while a set is being
// emitted; a stall on the output simply holds the current result.
// A synchronous reset empties the store and clears the overflow flag.
module weighted_record_insertion_sorter
    import wris_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  logic [RANK_W-1:0]   i_random_rank,
    input  logic [COORD_W-1:0]  i_box_x1,
    input  logic [COORD_W-1:0]  i_box_y1,
    input  logic [COORD_W-1:0]  i_box_x2,
    input  logic [COORD_W-1:0]  i_box_y2,
    input  logic                i_final_box,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [COORD_W-1:0]  o_out_x1,
    output logic [COORD_W-1:0]  o_out_y1,
    output logic [COORD_W-1:0]  o_out_x2,
    output logic [COORD_W-1:0]  o_out_y2,
    output logic [KEY_W-1:0]    o_sort_key,
    output logic                o_end_of_run,
    output logic                o_overflowed
);

    t_cmd             cmd;
    t_status          status;
    logic [BOX_W-1:0] out_box;

    wris_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The box is packed with x1 in the low bits, as in the store layout.
    wris_datapath #(
        .MaxBoxes (MAX_BOXES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_priority_req (i_priority_req),
        .i_random_rank  (i_random_rank),
        .i_box          ({i_box_y2, i_box_x2, i_box_y1, i_box_x1}),
        .i_final_box    (i_final_box),
        .o_box          (out_box),
        .o_sort_key     (o_sort_key),
        .o_end_of_run   (o_end_of_run),
        .o_overflowed   (o_overflowed)
    );

    assign o_out_x1 = out_box[COORD_W-1:0];
    assign o_out_y1 = out_box[2*COORD_W-1:COORD_W];
    assign o_out_x2 = out_box[3*COORD_W-1:2*COORD_W];
    assign o_out_y2 = out_box[4*COORD_W-1:3*COORD_W];

endmodule

// ===== sim/weighted_record_insertion_sorter_test.sv =====
// Testbench for the weighted record insertion sorter.
// Depends on wris_pkg and weighted_record_insertion_sorter; runs directed rows then random sets.
`timescale 1ns / 100ps

module weighted_record_insertion_sorter_test
    import wris_pkg::*;
();

    localparam int CAP        = MAX_BOXES_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 330;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [RANK_W-1:0]  rank;
        logic [COORD_W-1:0] x1, y1, x2, y2;
        logic               fin;
    } t_box_in;

    typedef struct packed {
        logic [COORD_W-1:0] x1, y1, x2, y2;
        logic [KEY_W-1:0]   key;
        logic               eor;
        logic               ovf;
    } t_sorted;

    // Directed row: the input and, where it is obvious, the typed-in result.
    typedef struct packed {
        t_box_in item;
        logic    has_exp;
        t_sorted exp;
    } t_row;

    logic               i_clk, i_rst_n, i_valid, i_ready, i_final_box;
    logic               o_ready, o_valid, o_end_of_run, o_overflowed;
    logic [PRIO_W-1:0]  i_priority_req;
    logic [RANK_W-1:0]  i_random_rank;
    logic [COORD_W-1:0] i_box_x1, i_box_y1, i_box_x2, i_box_y2;
    logic [COORD_W-1:0] o_out_x1, o_out_y1, o_out_x2, o_out_y2;
    logic [KEY_W-1:0]   o_sort_key;

    weighted_record_insertion_sorter uut (.*);

    // Predictor state: the sorted set being built.
    logic [KEY_W-1:0] pend_key[$];
    logic [BOX_W-1:0] pend_box[$];
    logic             pend_ovf;

    t_sorted sorted_expected[$];
    int      errors;
    bit      long_hold;
    bit      stim_done;
    t_row    rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // Inserts one accepted box and, on a final transfer, queues the whole set.
    task automatic sort_box(input t_box_in b);
        logic [KEY_W-1:0] key;
        int               pos;
        t_sorted          r;
        key = KEY_W'(b.prio) * KEY_W'(b.rank);
        if (pend_key.size() < CAP) begin
            // Stable insertion: land after every key less than or equal.
            pos = pend_key.size();
            while (pos > 0 && pend_key[pos-1] > key) pos--;
            pend_key.insert(pos, key);
            pend_box.insert(pos, {b.y2, b.x2, b.y1, b.x1});
        end else begin
            pend_ovf = 1'b1;
        end
        if (b.fin) begin
            foreach (pend_key[k]) begin
                {r.y2, r.x2, r.y1, r.x1} = pend_box[k];
                r.key = pend_key[k];
                r.eor = (k == pend_key.size() - 1);
                r.ovf = pend_ovf;
                sorted_expected.push_back(r);
            end
            pend_key.delete();
            pend_box.delete();
            pend_ovf = 1'b0;
        end
    endtask

    function automatic t_box_in random_box(input bit fin);
        t_box_in b;
        b.prio = PRIO_W'($urandom);
        b.rank = RANK_W'($urandom);
        b.x1 = COORD_W'($urandom); b.y1 = COORD_W'($urandom);
        b.x2 = COORD_W'($urandom); b.y2 = COORD_W'($urandom);
        // Narrow key ranges now and then so that equal keys occur.
        if ($urandom_range(0, 3) == 0) begin
            b.prio = PRIO_W'($urandom_range(0, 3));
            b.rank = RANK_W'($urandom_range(0, 2));
        end
        b.fin = fin;
        return b;
    endfunction

    // Drives one item; the valid stays up until a transfer takes it.
    task automatic send_box(input t_box_in b);
        i_valid        <= 1'b1;
        i_priority_req <= b.prio;
        i_random_rank  <= b.rank;
        i_box_x1 <= b.x1; i_box_y1 <= b.y1; i_box_x2 <= b.x2; i_box_y2 <= b.y2;
        i_final_box    <= b.fin;
        do @(posedge i_clk); while (!o_ready);
        sort_box(b);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_row mk_row(input t_box_in b, input bit he, input t_sorted e);
        t_row r;
        r.item = b; r.has_exp = he; r.exp = e;
        return r;
    endfunction

    function automatic t_box_in mk_box(input int p, input int rk, input int x1, input int y1,
                                       input int x2, input int y2, input bit f);
        t_box_in b;
        b.prio = PRIO_W'(p); b.rank = RANK_W'(rk);
        b.x1 = COORD_W'(x1); b.y1 = COORD_W'(y1);
        b.x2 = COORD_W'(x2); b.y2 = COORD_W'(y2);
        b.fin = f;
        return b;
    endfunction

    // Stimulus.
    initial begin
        t_sorted e;
        int      burst;
        int      left;
        int      setlen;
        i_rst_n = 1'b0; i_valid = 1'b0; i_final_box = 1'b0;
        i_priority_req = '0; i_random_rank = '0;
        i_box_x1 = '0; i_box_y1 = '0; i_box_x2 = '0; i_box_y2 = '0;
        errors = 0; pend_ovf = 1'b0; stim_done = 1'b0; long_hold = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A single-box set right after reset: all-zero box, zero key.
        e = '{x1: '0, y1: '0, x2: '0, y2: '0, key: '0, eor: 1'b1, ovf: 1'b0};
        rows.push_back(mk_row(mk_box(0, 0, 0, 0, 0, 0, 1'b1), 1'b1, e));
        // The largest key with all-ones coordinates.
        e = '{x1: 16'hffff, y1: 16'hffff, x2: 16'hffff, y2: 16'hffff,
              key: 22'd4128705, eor: 1'b1, ovf: 1'b0};
        rows.push_back(mk_row(mk_box(16'hffff, 63, 16'hffff, 16'hffff, 16'hffff,
                                     16'hffff, 1'b1), 1'b1, e));
        // Descending keys, then equal keys that must keep arrival order.
        rows.push_back(mk_row(mk_box(300, 5, 1, 2, 3, 4, 1'b0), 1'b0, '0));
        rows.push_back(mk_row(mk_box(200, 5, 5, 6, 7, 8, 1'b0), 1'b0, '0));
        rows.push_back(mk_row(mk_box(100, 10, 9, 10, 11, 12, 1'b0), 1'b0, '0));
        rows.push_back(mk_row(mk_box(1000, 1, 13, 14, 15, 16, 1'b0), 1'b0, '0));
        rows.push_back(mk_row(mk_box(16'hffff, 0, 16'haaaa, 16'h5555, 16'haaaa,
                                     16'h5555, 1'b0), 1'b0, '0));
        rows.push_back(mk_row(mk_box(0, 63, 16'h5555, 16'haaaa, 16'h5555,
                                     16'haaaa, 1'b1), 1'b0, '0));
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                // The typed-in result must agree with the predictor.
                sort_box(rows[i].item);
                if (sorted_expected[$] != rows[i].exp)
                    report_mismatch("directed row disagrees with predictor");
                void'(sorted_expected.pop_back());
                pend_key.delete(); pend_box.delete(); pend_ovf = 1'b0;
            end
            send_box(rows[i].item);
        end
        idle_gap(1);

        // Store full: fill to capacity plus extras, final item is dropped too.
        for (int k = 0; k < CAP + 3; k++) send_box(random_box(k == CAP + 2));
        // Long output stall while a full set is loaded and emitted.
        long_hold = 1'b1;
        for (int k = 0; k < CAP; k++) send_box(random_box(k == CAP - 1));
        for (int k = 0; k < 4; k++) send_box(random_box(k == 3));
        long_hold = 1'b0;

        // Random sets in bursts with gaps; mostly small sets.
        left = N_RANDOM;
        while (left > 0) begin
            setlen = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 2, CAP + 4)
                                                 : $urandom_range(1, 12);
            if (setlen > left) setlen = left;
            burst = $urandom_range(1, 8);
            for (int k = 0; k < setlen; k++) begin
                send_box(random_box(k == setlen - 1));
                if (--burst == 0) begin
                    idle_gap($urandom_range(0, 5));
                    burst = $urandom_range(1, 8);
                end
            end
            left -= setlen;
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall pattern, plus a long hold counted here.
    initial begin
        int hold;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold && hold < 600) begin
                hold++;
                i_ready <= 1'b0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       i_ready <= 1'b0;
                    default: i_ready <= 1'b1;
                endcase
            end
        end
    end

    // Checker: each output transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_sorted exp;
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_expected.size() == 0) begin
                report_mismatch("result with no expectation waiting");
            end else begin
                exp = sorted_expected.pop_front();
                if (o_out_x1 !== exp.x1) report_mismatch("out_x1");
                if (o_out_y1 !== exp.y1) report_mismatch("out_y1");
                if (o_out_x2 !== exp.x2) report_mismatch("out_x2");
                if (o_out_y2 !== exp.y2) report_mismatch("out_y2");
                if (o_sort_key !== exp.key) report_mismatch("sort_key");
                if (o_end_of_run !== exp.eor) report_mismatch("end_of_run");
                if (o_overflowed !== exp.ovf) report_mismatch("overflowed");
            end
        end
    end

    // Watchdog and end of run.
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (!(stim_done && sorted_expected.size() == 0)) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0 && sorted_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
